// ----- sv/twc_pkg.sv -----
`timescale 1ns / 1ps
package twc_pkg;

	// Geometry: powers of two only.
	localparam int BLOCK_BYTES = 32;
	localparam int SET_COUNT   = 16;

	localparam int ADDR_W   = 12;
	localparam int DATA_W   = 8;
	localparam int STATUS_W = 3;
	localparam int CNT_W    = 32;
	localparam int OFF_W    = $clog2(BLOCK_BYTES);
	localparam int SET_W    = $clog2(SET_COUNT);
	localparam int TAG_W    = ADDR_W - OFF_W - SET_W;
	localparam int LINE_W   = 1 + SET_W + OFF_W;   // way, set, offset

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_FILL  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MISS      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FILL_TAKE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FILL_DONE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd5;

	localparam logic [DATA_W-1:0] MISS_BYTE = 8'hFF;

	typedef struct packed {
		logic accept;   // look up and update on the input beat
		logic load;     // move the finished result into the output register
	} cmd_t;

	typedef struct packed {
		logic out_busy; // output register full and not being taken
	} stat_t;

endpackage

// ----- sv/twc_ctrl.sv -----
`timescale 1ns / 1ps
module twc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  twc_pkg::stat_t stat,
	output twc_pkg::cmd_t  cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RESP = 1'b1;

	logic state_q;

	assign in_ready   = (state_q == S_IDLE);
	assign cmd.accept = in_valid && in_ready;
	assign cmd.load   = (state_q == S_RESP) && !stat.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.accept) state_q <= S_RESP;
				end
				S_RESP: begin
					if (cmd.load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/twc_datapath.sv -----
`timescale 1ns / 1ps
module twc_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  twc_pkg::cmd_t                  cmd,
	output twc_pkg::stat_t                 stat,
	input  logic [1:0]                     operation,
	input  logic [twc_pkg::ADDR_W-1:0]     address,
	input  logic [twc_pkg::DATA_W-1:0]     data_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [twc_pkg::STATUS_W-1:0]   status,
	output logic [twc_pkg::DATA_W-1:0]     read_data,
	output logic                           fill_request,
	output logic [twc_pkg::ADDR_W-1:0]     fill_block_address,
	output logic                           memory_write_valid,
	output logic [twc_pkg::ADDR_W-1:0]     memory_write_address,
	output logic [twc_pkg::DATA_W-1:0]     memory_write_data,
	output logic [twc_pkg::CNT_W-1:0]      hits_so_far,
	output logic [twc_pkg::CNT_W-1:0]      misses_so_far
);

	localparam int OFF_W  = twc_pkg::OFF_W;
	localparam int SET_W  = twc_pkg::SET_W;
	localparam int TAG_W  = twc_pkg::TAG_W;
	localparam int LINE_W = twc_pkg::LINE_W;
	localparam int SETS   = twc_pkg::SET_COUNT;
	localparam int DEPTH  = 2 * twc_pkg::SET_COUNT * twc_pkg::BLOCK_BYTES;

	// tag store and line state, per way
	logic [TAG_W-1:0] tag0_q [SETS];
	logic [TAG_W-1:0] tag1_q [SETS];
	logic [SETS-1:0]  valid0_q, valid1_q, recent0_q, recent1_q;

	logic [twc_pkg::CNT_W-1:0] hit_cnt_q, miss_cnt_q;

	logic             fill_pending_q;
	logic             fill_way_q;
	logic [SET_W-1:0] fill_set_q;
	logic [TAG_W-1:0] fill_tag_q;
	logic [OFF_W-1:0] fill_cnt_q;

	// data store
	logic [twc_pkg::DATA_W-1:0] mem [DEPTH];
	logic [twc_pkg::DATA_W-1:0] mem_rd_q;
	logic                       mem_we, mem_re;
	logic [LINE_W-1:0]          mem_addr;

	// held result of the accepted beat
	logic [twc_pkg::STATUS_W-1:0] res_status_q;
	logic [twc_pkg::DATA_W-1:0]   res_rdata_q;
	logic                         res_rd_hit_q;
	logic                         res_freq_q;
	logic [twc_pkg::ADDR_W-1:0]   res_faddr_q;
	logic                         res_wvalid_q;
	logic [twc_pkg::ADDR_W-1:0]   res_waddr_q;
	logic [twc_pkg::DATA_W-1:0]   res_wdata_q;

	// output register
	logic                         out_valid_q;
	logic [twc_pkg::STATUS_W-1:0] out_status_q;
	logic [twc_pkg::DATA_W-1:0]   out_rdata_q;
	logic                         out_freq_q;
	logic [twc_pkg::ADDR_W-1:0]   out_faddr_q;
	logic                         out_wvalid_q;
	logic [twc_pkg::ADDR_W-1:0]   out_waddr_q;
	logic [twc_pkg::DATA_W-1:0]   out_wdata_q;
	logic [twc_pkg::CNT_W-1:0]    out_hits_q, out_misses_q;

	// lookup
	logic [OFF_W-1:0] off;
	logic [SET_W-1:0] set;
	logic [TAG_W-1:0] tag;
	logic             hit0, hit1, hit, hway;
	logic             is_rw, is_read, is_write, is_fill, fill_last;
	logic             do_hit, do_miss, do_fill;

	assign off  = address[OFF_W-1:0];
	assign set  = address[OFF_W +: SET_W];
	assign tag  = address[twc_pkg::ADDR_W-1 -: TAG_W];
	assign hit0 = valid0_q[set] && (tag0_q[set] == tag);
	assign hit1 = valid1_q[set] && (tag1_q[set] == tag);
	assign hit  = hit0 || hit1;
	assign hway = !hit0;   // way 0 wins when both match

	assign is_read   = (operation == twc_pkg::OP_READ);
	assign is_write  = (operation == twc_pkg::OP_WRITE);
	assign is_fill   = (operation == twc_pkg::OP_FILL);
	assign is_rw     = is_read || is_write;
	assign fill_last = (fill_cnt_q == {OFF_W{1'b1}});

	assign do_hit  = cmd.accept && is_rw && !fill_pending_q && hit;
	assign do_miss = cmd.accept && is_rw && !fill_pending_q && !hit;
	assign do_fill = cmd.accept && is_fill && fill_pending_q;

	// data store port: fill writes the victim line, hits go to the hit line
	assign mem_we   = do_fill || (do_hit && is_write);
	assign mem_re   = do_hit && is_read;
	assign mem_addr = do_fill ? {fill_way_q, fill_set_q, fill_cnt_q} : {hway, set, off};

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= data_in;
		if (mem_re) mem_rd_q <= mem[mem_addr];
	end

	// line state, fill tracking, counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SETS; i++) begin
				tag0_q[i] <= '0;
				tag1_q[i] <= '0;
			end
			valid0_q       <= '0;
			valid1_q       <= '0;
			recent0_q      <= '0;
			recent1_q      <= '0;
			hit_cnt_q      <= '0;
			miss_cnt_q     <= '0;
			fill_pending_q <= 1'b0;
			fill_way_q     <= 1'b0;
			fill_set_q     <= '0;
			fill_tag_q     <= '0;
			fill_cnt_q     <= '0;
		end else begin
			if (do_hit) begin
				if (hit_cnt_q != '1) hit_cnt_q <= hit_cnt_q + 1'b1;
				recent0_q[set] <= !hway;
				recent1_q[set] <= hway;
			end
			if (do_miss) begin
				if (miss_cnt_q != '1) miss_cnt_q <= miss_cnt_q + 1'b1;
				if (is_read) begin
					fill_pending_q <= 1'b1;
					fill_way_q     <= recent0_q[set];
					fill_set_q     <= set;
					fill_tag_q     <= tag;
					fill_cnt_q     <= '0;
				end
			end
			if (do_fill) begin
				fill_cnt_q <= fill_cnt_q + 1'b1;   // wraps to zero after the last byte
				if (fill_last) begin
					fill_pending_q         <= 1'b0;
					recent0_q[fill_set_q] <= !fill_way_q;
					recent1_q[fill_set_q] <= fill_way_q;
					if (fill_way_q) begin
						tag1_q[fill_set_q]   <= fill_tag_q;
						valid1_q[fill_set_q] <= 1'b1;
					end else begin
						tag0_q[fill_set_q]   <= fill_tag_q;
						valid0_q[fill_set_q] <= 1'b1;
					end
				end
			end
		end
	end

	// result of the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_rd_hit_q <= do_hit && is_read;
			res_rdata_q  <= (do_miss && is_read) ? twc_pkg::MISS_BYTE : '0;
			res_freq_q   <= do_miss && is_read;
			res_faddr_q  <= (do_miss && is_read) ? {tag, set, {OFF_W{1'b0}}} : '0;
			res_wvalid_q <= is_write && !fill_pending_q;
			res_waddr_q  <= (is_write && !fill_pending_q) ? address : '0;
			res_wdata_q  <= (is_write && !fill_pending_q) ? data_in : '0;
			priority if (is_rw && fill_pending_q) res_status_q <= twc_pkg::ST_BUSY;
			else if (is_rw && hit)                res_status_q <= twc_pkg::ST_HIT;
			else if (is_rw)                       res_status_q <= twc_pkg::ST_MISS;
			else if (do_fill && fill_last)        res_status_q <= twc_pkg::ST_FILL_DONE;
			else if (do_fill)                     res_status_q <= twc_pkg::ST_FILL_TAKE;
			else                                  res_status_q <= twc_pkg::ST_IGNORED;
		end
	end

	// output register
	assign stat.out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_status_q <= res_status_q;
			out_rdata_q  <= res_rd_hit_q ? mem_rd_q : res_rdata_q;
			out_freq_q   <= res_freq_q;
			out_faddr_q  <= res_faddr_q;
			out_wvalid_q <= res_wvalid_q;
			out_waddr_q  <= res_waddr_q;
			out_wdata_q  <= res_wdata_q;
			out_hits_q   <= hit_cnt_q;
			out_misses_q <= miss_cnt_q;
		end
	end

	assign out_valid            = out_valid_q;
	assign status               = out_status_q;
	assign read_data            = out_rdata_q;
	assign fill_request         = out_freq_q;
	assign fill_block_address   = out_faddr_q;
	assign memory_write_valid   = out_wvalid_q;
	assign memory_write_address = out_waddr_q;
	assign memory_write_data    = out_wdata_q;
	assign hits_so_far          = out_hits_q;
	assign misses_so_far        = out_misses_q;

	a_busy_when_filling: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && is_rw && fill_pending_q |=> res_status_q == twc_pkg::ST_BUSY)
		else $error("access during fill not refused");

	a_fill_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		do_fill && fill_last |=> !fill_pending_q && fill_cnt_q == '0)
		else $error("last fill byte did not close the fill");

	a_read_miss_opens_fill: assert property (@(posedge clk) disable iff (!arst_n)
		do_miss && is_read |=> fill_pending_q && fill_cnt_q == '0)
		else $error("read miss did not open a fill");

	a_one_counter_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(hit_cnt_q) |-> $stable(miss_cnt_q))
		else $error("hit and miss counters moved together");

endmodule

// ----- sv/two_way_write_through_cache.sv -----
`timescale 1ns / 1ps
// Two-way set-associative byte cache, write-through with no write allocate.
// 12-bit byte address: tag in the high bits, then set, then block offset
// (16 sets of 32-byte lines at the default geometry). operation 0 reads a
// byte, 1 writes one, 2 delivers the next byte of a pending line fill. A read
// miss answers 255 with fill_request and the block address; the next 32 fill
// beats load the victim way (way 0 if it is the older one, otherwise way 1),
// and the last one makes the line valid and recent. Any read or write while
// a fill is open comes back busy and changes nothing. Every accepted write
// outside a fill shows up on memory_write_* whether it hit or not.
// hits_so_far and misses_so_far saturate at 2^32-1 and ride on every result beat.
// The lookup, tag/recency update and data store access happen on the accept
// edge; the synchronous data store read and the held result then move into
// the output register once it is empty or being taken.
// The output register lets the next input beat be taken while a result still
// waits downstream. One result beat per input beat. Data bytes of a line are
// not cleared at reset; they are only visible after a complete fill.
module two_way_write_through_cache (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     operation,
	input  logic [twc_pkg::ADDR_W-1:0]     address,
	input  logic [twc_pkg::DATA_W-1:0]     data_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [twc_pkg::STATUS_W-1:0]   status,
	output logic [twc_pkg::DATA_W-1:0]     read_data,
	output logic                           fill_request,
	output logic [twc_pkg::ADDR_W-1:0]     fill_block_address,
	output logic                           memory_write_valid,
	output logic [twc_pkg::ADDR_W-1:0]     memory_write_address,
	output logic [twc_pkg::DATA_W-1:0]     memory_write_data,
	output logic [twc_pkg::CNT_W-1:0]      hits_so_far,
	output logic [twc_pkg::CNT_W-1:0]      misses_so_far
);

	twc_pkg::cmd_t  cmd;
	twc_pkg::stat_t stat;

	// sequencing: idle -> result pending -> idle
	twc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// tags, line state, data store, counters and output register
	twc_datapath u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.stat                 (stat),
		.operation            (operation),
		.address              (address),
		.data_in              (data_in),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.status               (status),
		.read_data            (read_data),
		.fill_request         (fill_request),
		.fill_block_address   (fill_block_address),
		.memory_write_valid   (memory_write_valid),
		.memory_write_address (memory_write_address),
		.memory_write_data    (memory_write_data),
		.hits_so_far          (hits_so_far),
		.misses_so_far        (misses_so_far)
	);

endmodule
